[rtl/csmab_pkg.sv]
// ----------------------------------------------------------------------------
// csmab_pkg
// Shared types and constants for the CSMA/CA station backoff block.
// ----------------------------------------------------------------------------
package csmab_pkg;

  // Register map: index = byte address / 4
  localparam int unsigned ADDR_WIDTH = 4;
  localparam int unsigned DATA_WIDTH = 32;

  localparam logic [1:0] REG_SLOT_TIME    = 2'd0;
  localparam logic [1:0] REG_FRAME_LENGTH = 2'd1;
  localparam logic [1:0] REG_CW_MIN_EXP   = 2'd2;
  localparam logic [1:0] REG_CW_MAX_EXP   = 2'd3;

  // Register reset values
  localparam logic [9:0]  SLOT_TIME_RST    = 10'd9;
  localparam logic [15:0] FRAME_LENGTH_RST = 16'd500;
  localparam logic [3:0]  CW_MIN_EXP_RST   = 4'd5;
  localparam logic [3:0]  CW_MAX_EXP_RST   = 4'd10;

  // Largest usable window exponent (window of 4096 slots)
  localparam logic [3:0]  EXP_CAP          = 4'd12;
  localparam logic [3:0]  WINDOW_EXP_RST   = 4'd5;

  // Configuration handed from the register file to the datapath
  typedef struct packed {
    logic [9:0]  slot_time;
    logic [15:0] frame_length;
    logic [3:0]  cw_min_exp;
    logic [3:0]  cw_max_exp;
  } cfg_t;

  // One tick of station input
  typedef struct packed {
    logic        packet_arrival;
    logic        channel_idle;
    logic [11:0] random_draw;
  } in_item_t;

  // One tick of station status
  typedef struct packed {
    logic        transmitting;
    logic        tx_start;
    logic        tx_end;
    logic        success;
    logic        collision;
    logic [15:0] delay_add;
    logic [12:0] contention_window;
    logic [15:0] pending_packets;
  } out_item_t;

  // Exponent clamped to the largest supported window
  function automatic logic [3:0] eff_exp(input logic [3:0] e);
    return (e > EXP_CAP) ? EXP_CAP : e;
  endfunction

endpackage

[rtl/csmab_stream_if.sv]
// ----------------------------------------------------------------------------
// csmab_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface csmab_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[rtl/csmab_apb_regs.sv]
// ----------------------------------------------------------------------------
// csmab_apb_regs
// APB-style configuration registers: slot time, frame length, window limits.
// ----------------------------------------------------------------------------
module csmab_apb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [csmab_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [csmab_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [csmab_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                                pready,
  output csmab_pkg::cfg_t                     cfg_o
);
  import csmab_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SLOT_TIME:    cfg_d.slot_time    = pwdata[9:0];
        REG_FRAME_LENGTH: cfg_d.frame_length = pwdata[15:0];
        REG_CW_MIN_EXP:   cfg_d.cw_min_exp   = pwdata[3:0];
        REG_CW_MAX_EXP:   cfg_d.cw_max_exp   = pwdata[3:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slot_time    <= SLOT_TIME_RST;
      cfg_q.frame_length <= FRAME_LENGTH_RST;
      cfg_q.cw_min_exp   <= CW_MIN_EXP_RST;
      cfg_q.cw_max_exp   <= CW_MAX_EXP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_SLOT_TIME:    prdata = DATA_WIDTH'(cfg_q.slot_time);
      REG_FRAME_LENGTH: prdata = DATA_WIDTH'(cfg_q.frame_length);
      REG_CW_MIN_EXP:   prdata = DATA_WIDTH'(cfg_q.cw_min_exp);
      REG_CW_MAX_EXP:   prdata = DATA_WIDTH'(cfg_q.cw_max_exp);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/csma_ca_station_backoff.sv]
// ----------------------------------------------------------------------------
// csma_ca_station_backoff
// CSMA/CA station MAC timer with binary exponential backoff.
// ----------------------------------------------------------------------------
// One input request is one channel tick. The block takes a request every clock
// while the sink keeps up and delivers its status from an output register in
// the next cycle; a new request is taken while that status waits, as long as
// the sink takes it in the same cycle. The full tick (backoff count, frame
// timer, window update and the slot-count times slot-time multiply of a redraw)
// is done in one pass between the state registers and the output register, so
// throughput is one item per clock unless the sink stalls. The very first
// request loads the window from cw_min_exp and draws the first backoff from
// its random_draw. Registers: slot_time @0x0, frame_length @0x4, cw_min_exp
// @0x8, cw_max_exp @0xC; exponents above 12 are used as 12.
module csma_ca_station_backoff #(
  parameter int unsigned PENDING_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  csmab_stream_if.sink                     in_if,
  csmab_stream_if.source                   out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [csmab_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [csmab_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [csmab_pkg::DATA_WIDTH-1:0] prdata,
  output logic                             pready
);
  import csmab_pkg::*;

  localparam logic [PENDING_WIDTH-1:0] PEND_MAX = '1;

  cfg_t cfg;

  // Station state
  logic [PENDING_WIDTH-1:0] pend_q, pend_d;
  logic [22:0]              backoff_q, backoff_d;
  logic                     drawn_q;
  logic [3:0]               wexp_q, wexp_d;
  logic                     sending_q, sending_d;
  logic                     first_q, first_d;
  logic [15:0]              frame_q, frame_d;

  // Output register
  logic                     out_valid_q;
  out_item_t                out_q, out_d;

  // Per-tick working values
  in_item_t                 item;
  logic                     accept;
  logic [3:0]               emin, emax;
  logic [3:0]               wexp_base;
  logic [22:0]              backoff_base;
  logic [12:0]              win_mask;
  logic [12:0]              slots;
  logic [22:0]              redraw;
  logic [PENDING_WIDTH-1:0] pend_a;
  logic [4:0]               wexp_inc;
  logic [3:0]               wexp_dec;
  logic                     start_c, end_c, succ_c, coll_c;
  logic [15:0]              delay_c;
  logic [31:0]              pend_ext;

  csmab_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: output register drains or is free
  assign item         = in_if.payload;
  assign in_if.ready  = !out_valid_q || out_if.ready;
  assign accept       = in_if.valid && in_if.ready;

  assign emin = eff_exp(cfg.cw_min_exp);
  assign emax = eff_exp(cfg.cw_max_exp);

  // First tick loads the window from the minimum before anything else
  assign wexp_base = drawn_q ? wexp_q : emin;

  // Backoff redraw: ((draw mod window) + 1) * slot_time, shared by first draw
  // and frame end (they never fall on the same tick)
  assign win_mask = (13'd1 << wexp_base) - 13'd1;
  assign slots    = 13'(item.random_draw & win_mask[11:0]) + 13'd1;
  assign redraw   = 23'(slots) * 23'(cfg.slot_time);

  assign backoff_base = drawn_q ? backoff_q : redraw;

  // Arrival counted first, saturating
  assign pend_a = (item.packet_arrival && (pend_q != PEND_MAX)) ?
                  pend_q + 1'b1 : pend_q;

  assign wexp_inc = {1'b0, wexp_base} + 5'd1;
  assign wexp_dec = (wexp_base != 4'd0) ? wexp_base - 4'd1 : 4'd0;

  // Tick update
  always_comb begin
    pend_d    = pend_a;
    backoff_d = backoff_base;
    wexp_d    = wexp_base;
    sending_d = sending_q;
    first_d   = first_q;
    frame_d   = frame_q;
    start_c   = 1'b0;
    end_c     = 1'b0;
    succ_c    = 1'b0;
    coll_c    = 1'b0;
    delay_c   = '0;

    if (pend_a != '0) begin
      if (!sending_q && item.channel_idle) begin
        // Backoff countdown while the medium is free
        delay_c = 16'd1;
        if (backoff_base <= 23'd1) begin
          backoff_d = '0;
          sending_d = 1'b1;
          first_d   = 1'b1;
          frame_d   = cfg.frame_length;
          start_c   = 1'b1;
        end else begin
          backoff_d = backoff_base - 23'd1;
        end
      end else if (sending_q) begin
        if (first_q) begin
          // First frame tick decides success or collision
          first_d = 1'b0;
          if (frame_q != '0) frame_d = frame_q - 16'd1;
          if (item.channel_idle) begin
            succ_c = 1'b1;
            wexp_d = (wexp_dec < emin) ? emin : wexp_dec;
          end else begin
            coll_c  = 1'b1;
            delay_c = cfg.frame_length;
            wexp_d  = (wexp_inc > {1'b0, emax}) ? emax : wexp_inc[3:0];
          end
        end else if (frame_q <= 16'd1) begin
          // Frame end: release, redraw, retire on a free medium
          frame_d   = '0;
          sending_d = 1'b0;
          backoff_d = redraw;
          end_c     = 1'b1;
          if (item.channel_idle) pend_d = pend_a - 1'b1;
        end else begin
          frame_d = frame_q - 16'd1;
        end
      end else begin
        // Deferring behind a busy medium
        delay_c = 16'd1;
      end
    end
  end

  assign pend_ext = 32'(pend_d);

  // Status for this tick
  always_comb begin
    out_d.transmitting      = sending_d;
    out_d.tx_start          = start_c;
    out_d.tx_end            = end_c;
    out_d.success           = succ_c;
    out_d.collision         = coll_c;
    out_d.delay_add         = delay_c;
    out_d.contention_window = 13'd1 << wexp_d;
    out_d.pending_packets   = pend_ext[15:0];
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      backoff_q <= '0;
      drawn_q   <= 1'b0;
      wexp_q    <= WINDOW_EXP_RST;
      sending_q <= 1'b0;
      first_q   <= 1'b0;
      frame_q   <= '0;
    end else if (accept) begin
      pend_q    <= pend_d;
      backoff_q <= backoff_d;
      drawn_q   <= 1'b1;
      wexp_q    <= wexp_d;
      sending_q <= sending_d;
      first_q   <= first_d;
      frame_q   <= frame_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

`ifndef SYNTHESIS
  // A started frame shows as transmitting in the next status
  a_start_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && start_c |=> out_if.valid && out_if.payload.transmitting)
    else $error("frame start not reported as transmitting");

  // Window exponent stays within the supported range once loaded
  a_wexp_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drawn_q |-> wexp_q <= EXP_CAP)
    else $error("window exponent out of range");

  // Success or collision only on a frame in progress, never both
  a_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.success || out_q.collision) |->
      out_q.transmitting && !(out_q.success && out_q.collision))
    else $error("bad frame outcome flags");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CSMA/CA station backoff block. A model of the
// station in the scoreboard predicts the status of every accepted tick request.
// Each status the block hands out is compared field by field with the oldest
// prediction. Stimulus is a short directed run through the backoff, frame and
// window corner cases, then random ticks under several register settings, with
// a late back-to-back burst of busy-channel ticks, each with an arrival.
// ----------------------------------------------------------------------------
module tb;
  import csmab_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 40;

  // Predicts one status per tick request and checks what the block returns
  class mac_scoreboard;
    logic [9:0]  slot_time;
    logic [15:0] frame_len;
    logic [3:0]  cw_lo;
    logic [3:0]  cw_hi;
    logic [15:0] pend;
    logic [22:0] backoff;
    logic [3:0]  wexp;
    logic [15:0] frame_left;
    bit          drawn;
    bit          sending;
    bit          opening_tick;
    out_item_t   status_due [$];
    int          errors;

    function new();
      slot_time    = SLOT_TIME_RST;
      frame_len    = FRAME_LENGTH_RST;
      cw_lo        = CW_MIN_EXP_RST;
      cw_hi        = CW_MAX_EXP_RST;
      pend         = '0;
      backoff      = '0;
      wexp         = WINDOW_EXP_RST;
      frame_left   = '0;
      drawn        = 1'b0;
      sending      = 1'b0;
      opening_tick = 1'b0;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_SLOT_TIME:    slot_time = val[9:0];
        REG_FRAME_LENGTH: frame_len = val[15:0];
        REG_CW_MIN_EXP:   cw_lo = val[3:0];
        REG_CW_MAX_EXP:   cw_hi = val[3:0];
        default: ;
      endcase
    endfunction

    // New backoff: (draw masked to the window, plus one) slots
    function void redraw(logic [11:0] draw);
      int unsigned mask;
      mask = (32'd1 << wexp) - 1;
      backoff = 23'(((32'(draw) & mask) + 1) * slot_time);
    endfunction

    function void note_request(in_item_t r);
      out_item_t  o;
      logic [3:0] lo_exp;
      logic [3:0] hi_exp;
      lo_exp = (cw_lo > EXP_CAP) ? EXP_CAP : cw_lo;
      hi_exp = (cw_hi > EXP_CAP) ? EXP_CAP : cw_hi;
      o = '0;
      // very first request loads the window and draws the first backoff
      if (!drawn) begin
        wexp = lo_exp;
        redraw(r.random_draw);
        drawn = 1'b1;
      end
      if (r.packet_arrival && pend != 16'hFFFF) pend++;
      if (pend != 0) begin
        if (!sending && r.channel_idle) begin
          // counting down; a count of 0 or 1 starts the frame
          o.delay_add = 16'd1;
          if (backoff <= 1) begin
            backoff      = '0;
            sending      = 1'b1;
            opening_tick = 1'b1;
            frame_left   = frame_len;
            o.tx_start   = 1'b1;
          end else begin
            backoff--;
          end
        end else if (sending) begin
          if (opening_tick) begin
            opening_tick = 1'b0;
            if (frame_left != 0) frame_left--;
            if (r.channel_idle) begin
              o.success = 1'b1;
              if (wexp != 0) wexp--;
              if (wexp < lo_exp) wexp = lo_exp;
            end else begin
              o.collision = 1'b1;
              o.delay_add = frame_len;
              wexp++;
              if (wexp > hi_exp) wexp = hi_exp;
            end
          end else if (frame_left <= 1) begin
            // frame end: redraw, and drop a packet on an idle channel
            frame_left = '0;
            sending    = 1'b0;
            redraw(r.random_draw);
            if (r.channel_idle && pend != 0) pend--;
            o.tx_end = 1'b1;
          end else begin
            frame_left--;
          end
        end else begin
          o.delay_add = 16'd1;
        end
      end
      o.transmitting      = sending;
      o.contention_window = 13'(1) << wexp;
      o.pending_packets   = pend;
      status_due.push_back(o);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (status_due.size() == 0) begin
        $display("%0t: status expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = status_due.pop_front();
      cmp_field("transmitting", want.transmitting, got.transmitting);
      cmp_field("tx_start", want.tx_start, got.tx_start);
      cmp_field("tx_end", want.tx_end, got.tx_end);
      cmp_field("success", want.success, got.success);
      cmp_field("collision", want.collision, got.collision);
      cmp_field("delay_add", want.delay_add, got.delay_add);
      cmp_field("contention_window", want.contention_window, got.contention_window);
      cmp_field("pending_packets", want.pending_packets, got.pending_packets);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  csmab_stream_if #(.T(in_item_t))  req_if ();
  csmab_stream_if #(.T(out_item_t)) stat_if ();

  mac_scoreboard sb;
  bit            steady   = 1'b0;
  int            hold_len = 0;
  int unsigned   stall_cnt = 0;

  // Directed ticks {arrival, idle, draw}; the second half runs with slot 0,
  // frame length 0, minimum exponent 13 and maximum exponent 1
  in_item_t opening_seq [26] = '{
    {1'b0, 1'b1, 12'd4095}, {1'b1, 1'b1, 12'd0},    {1'b0, 1'b1, 12'd0},
    {1'b0, 1'b0, 12'd4095}, {1'b1, 1'b0, 12'd0},    {1'b0, 1'b1, 12'd0},
    {1'b1, 1'b0, 12'd0},    {1'b0, 1'b1, 12'd4095}, {1'b0, 1'b1, 12'd0},
    {1'b0, 1'b1, 12'd0},    {1'b0, 1'b0, 12'd0},    {1'b0, 1'b0, 12'd3},
    {1'b0, 1'b0, 12'd0},
    {1'b0, 1'b1, 12'd0},    {1'b0, 1'b1, 12'd0},    {1'b0, 1'b1, 12'd0},
    {1'b0, 1'b1, 12'd0},    {1'b0, 1'b0, 12'd0},    {1'b0, 1'b1, 12'd0},
    {1'b0, 1'b1, 12'd0},    {1'b0, 1'b1, 12'd0},    {1'b0, 1'b1, 12'd4095},
    {1'b0, 1'b1, 12'd0},    {1'b1, 1'b1, 12'd0},    {1'b0, 1'b0, 12'd0},
    {1'b0, 1'b0, 12'd4095}
  };

  csma_ca_station_backoff #(
    .PENDING_WIDTH(16)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (req_if),
    .out_if  (stat_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Note requests and check statuses as they are accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.payload);
      if (stat_if.valid && stat_if.ready) sb.check_result(stat_if.payload);
    end
  end

  // Watchdog: too long without any request or status moving ends the run
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (stat_if.valid && stat_if.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Status sink: random stalls, plus an occasional long hold-off
  initial begin : status_sink
    int stall;
    stat_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(4);
      stall += hold_len;
      hold_len = 0;
      if (stall > 0) begin
        stat_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      stat_if.ready <= 1'b1;
      do @(posedge clk_i); while (!stat_if.valid);
      @(negedge clk_i);
    end
  end

  function automatic in_item_t random_tick(int arr_pct, int idle_pct);
    in_item_t r;
    int       pick;
    pick = $urandom_range(9);
    r.packet_arrival = ($urandom_range(99) < arr_pct);
    r.channel_idle   = ($urandom_range(99) < idle_pct);
    r.random_draw    = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : 12'($urandom);
    return r;
  endfunction

  task automatic send_request(in_item_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(4);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Stop offering requests until every status has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.status_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(int unsigned slot, int unsigned frame, int unsigned lo,
                            int unsigned hi);
    drain();
    write_reg(REG_SLOT_TIME, slot);
    write_reg(REG_FRAME_LENGTH, frame);
    write_reg(REG_CW_MIN_EXP, lo);
    write_reg(REG_CW_MAX_EXP, hi);
  endtask

  // One register setting, then random ticks; squeeze adds a long sink
  // hold-off halfway and a full drain at three quarters
  task automatic run_phase(int unsigned slot, int unsigned frame, int unsigned lo,
                           int unsigned hi, int count, int arr_pct, int idle_pct,
                           bit squeeze);
    set_config(slot, frame, lo, hi);
    for (int k = 0; k < count; k++) begin
      if (squeeze && k == count / 2) hold_len = LONG_HOLD;
      if (squeeze && k == (3 * count) / 4) drain();
      send_request(random_tick(arr_pct, idle_pct));
    end
  endtask

  initial begin : stimulus
    sb             = new();
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: first draw, start, success, collision, drop, slot 0, short
    // frames, exponent above 12, minimum above maximum, nothing pending
    set_config(1, 2, 0, 2);
    foreach (opening_seq[i]) begin
      if (i == 13) set_config(0, 0, 13, 1);
      send_request(opening_seq[i]);
    end

    // random settings; all but the last keep the backoff short enough to see frames
    run_phase(1, 3, 6, 2, 120, 30, 80, 1'b0);
    run_phase(2, 4, 1, 5, 120, 30, 80, 1'b1);
    run_phase(0, 0, 2, 6, 120, 40, 75, 1'b0);
    run_phase(1, 1, 0, 0, 120, 30, 80, 1'b1);
    run_phase(5, 10, 3, 3, 120, 5, 85, 1'b0);
    run_phase(1023, 65535, 0, 0, 100, 30, 80, 1'b0);

    // busy channel with an arrival every tick, back to back, then a mixed phase
    steady = 1'b1;
    run_phase(1023, 65535, 12, 15, 20, 100, 0, 1'b0);
    steady = 1'b0;
    run_phase(1023, 65535, 12, 15, 30, 60, 80, 1'b0);

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.status_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/csmab_pkg.sv
rtl/csmab_stream_if.sv
rtl/csmab_apb_regs.sv
rtl/csma_ca_station_backoff.sv
tb/tb.sv
